// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock with active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock, disabled while the active-low reset is low.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion on the block clock and reset.
`define ASSERT_TOP(lbl, prop, msg) `ASSERT_CLK_RST(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== src/tdss_pkg.sv =====
// ----------------------------------------------------------------------------
// tdss_pkg
// Types, codes and widths shared by the two door servo sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdss_pkg;

    // Width of the tick counters, which saturate at their all-ones value.
    localparam int TIMER_BITS = 16;
    localparam int CMP_W      = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    typedef logic [TIMER_BITS-1:0] t_timer;
    typedef logic [CMP_W-1:0]      t_cmp;

    localparam t_timer TIMER_MAX = '1;

    // Configuration port geometry.
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes.
    localparam logic [2:0] REG_OPEN0    = 3'd0;
    localparam logic [2:0] REG_OPEN1    = 3'd1;
    localparam logic [2:0] REG_CLOSE0   = 3'd2;
    localparam logic [2:0] REG_CLOSE1   = 3'd3;
    localparam logic [2:0] REG_PRE_MODE = 3'd4;
    localparam logic [2:0] REG_POST_MODE = 3'd5;
    localparam logic [2:0] REG_DELAY    = 3'd6;
    localparam logic [2:0] REG_SETTLE   = 3'd7;

    // Item kinds.
    localparam logic [2:0] KIND_TICK       = 3'd0;
    localparam logic [2:0] KIND_START_OPEN = 3'd1;
    localparam logic [2:0] KIND_START_CLOSE = 3'd2;
    localparam logic [2:0] KIND_OPEN_NOW   = 3'd3;
    localparam logic [2:0] KIND_CLOSE_NOW  = 3'd4;
    localparam logic [2:0] KIND_SET_POS    = 3'd5;

    // Door modes; codes five to seven are stored as written.
    localparam logic [2:0] DM_NONE   = 3'd0;
    localparam logic [2:0] DM_SINGLE = 3'd1;
    localparam logic [2:0] DM_SYNC   = 3'd2;
    localparam logic [2:0] DM_DELAY  = 3'd3;
    localparam logic [2:0] DM_SEQ    = 3'd4;

    typedef enum logic [1:0] {
        SEQ_IDLE     = 2'd0,
        SEQ_OPENING  = 2'd1,
        SEQ_CLOSING  = 2'd2,
        SEQ_COMPLETE = 2'd3
    } t_seq;

    typedef enum logic [1:0] {
        DS_CLOSED  = 2'd0,
        DS_OPENING = 2'd1,
        DS_OPEN    = 2'd2,
        DS_CLOSING = 2'd3
    } t_doors;

    // Configuration registers as seen by the sequencer.
    typedef struct packed {
        logic [15:0] door0_open_pw;
        logic [15:0] door1_open_pw;
        logic [15:0] door0_shut_pw;
        logic [15:0] door1_shut_pw;
        logic [2:0]  pre_mode;
        logic [2:0]  post_mode;
        logic [15:0] lag_ticks;
        logic [15:0] settle_ms;
    } t_cfg;

    // One input beat.
    typedef struct packed {
        logic [2:0]  mode;
        logic        deploying;
        logic        door_index;
        logic [15:0] target_pw;
        logic        door0_ready;
        logic        door1_ready;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic        door0_cmd_valid;
        logic [15:0] door0_cmd_us;
        logic        door1_cmd_valid;
        logic [15:0] door1_cmd_us;
        logic [1:0]  sequence_state;
        logic [1:0]  door_position_state;
    } t_result;

endpackage

// ===== src/tdss_if.sv =====
// ----------------------------------------------------------------------------
// tdss_in_if / tdss_out_if
// Valid/ready channels for sequencer items and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tdss_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic        deploying;
    logic        door_index;
    logic [15:0] target_pw;
    logic        door0_ready;
    logic        door1_ready;

    modport source (
        output valid, mode, deploying, door_index, target_pw, door0_ready, door1_ready,
        input  ready
    );
    modport sink (
        input  valid, mode, deploying, door_index, target_pw, door0_ready, door1_ready,
        output ready
    );
endinterface

interface tdss_out_if;
    logic        valid;
    logic        ready;
    logic        door0_cmd_valid;
    logic [15:0] door0_cmd_us;
    logic        door1_cmd_valid;
    logic [15:0] door1_cmd_us;
    logic [1:0]  sequence_state;
    logic [1:0]  door_position_state;

    modport source (
        output valid, door0_cmd_valid, door0_cmd_us, door1_cmd_valid, door1_cmd_us,
               sequence_state, door_position_state,
        input  ready
    );
    modport sink (
        input  valid, door0_cmd_valid, door0_cmd_us, door1_cmd_valid, door1_cmd_us,
               sequence_state, door_position_state,
        output ready
    );
endinterface

// ===== src/two_door_servo_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// two_door_servo_sequencer_top
// Sequences two door servos from tick, start, immediate and position beats.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Carries
//  i_item    in         valid/ready         item kind, deploy flag, door, ready flags
//  o_result  out        valid/ready         door commands, sequence and door states
//  APB       in/out     psel/penable/pready register writes and reads
//
//  Each beat passes an input register and then a result register; one beat is taken
//  in every cycle while the result register is empty or being taken.
//  The sequencer state updates as a beat moves from the input register into
//  the result register. A stalled result holds both stages; an empty input
//  register still takes one beat, and then the input stalls as well. Reset is
//  synchronous; no clearing pass follows.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_door_servo_sequencer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tdss_in_if.sink                       i_item,
    tdss_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tdss_pkg::ADDR_W-1:0]   paddr,
    input  logic [tdss_pkg::DATA_W-1:0]   pwdata,
    output logic [tdss_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    tdss_pkg::t_cfg    cfg;

    // Pipeline registers.
    logic              r_s1_valid;
    tdss_pkg::t_item   r_s1;
    logic              r_out_valid;
    tdss_pkg::t_result r_out;
    tdss_pkg::t_result n_out;
    logic              advance;

    // Sequencer state.
    tdss_pkg::t_seq    r_seq, n_seq;
    tdss_pkg::t_doors  r_doors, n_doors;
    logic [2:0]        r_act, n_act;
    logic              r_dir, n_dir;
    logic              r_second, n_second;
    tdss_pkg::t_timer  r_settle, n_settle;
    tdss_pkg::t_timer  r_phase, n_phase;

    // Step working signals.
    logic              cmd0_v, cmd1_v;
    logic [15:0]       cmd0_us, cmd1_us;
    logic [2:0]        start_mode;
    logic              closing;
    logic              rf, rs;
    logic              chk_en, chk_ready;
    logic              launch;
    tdss_pkg::t_timer  settle_inc, phase_inc;

    tdss_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Handshake: the result register frees when empty or taken.
    assign advance      = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || advance;

    assign settle_inc = (r_settle == tdss_pkg::TIMER_MAX) ? r_settle : r_settle + 1'b1;
    assign phase_inc  = (r_phase == tdss_pkg::TIMER_MAX) ? r_phase : r_phase + 1'b1;
    assign rf         = r_dir ? r_s1.door1_ready : r_s1.door0_ready;
    assign rs         = r_dir ? r_s1.door0_ready : r_s1.door1_ready;

    // One sequencer step for the beat in the input register.
    always_comb begin
        n_seq     = r_seq;
        n_doors   = r_doors;
        n_act     = r_act;
        n_dir     = r_dir;
        n_second  = r_second;
        n_settle  = r_settle;
        n_phase   = r_phase;
        cmd0_v    = 1'b0;
        cmd1_v    = 1'b0;
        cmd0_us   = '0;
        cmd1_us   = '0;
        chk_en    = 1'b0;
        chk_ready = 1'b0;
        launch    = 1'b0;
        closing   = (r_s1.mode == tdss_pkg::KIND_START_CLOSE)
                 || (r_s1.mode == tdss_pkg::KIND_CLOSE_NOW);
        // Opening reads pre mode while deploying, closing reads it otherwise.
        start_mode = (r_s1.deploying ^ closing) ? cfg.pre_mode : cfg.post_mode;

        case (r_s1.mode)
            tdss_pkg::KIND_TICK: begin
                n_settle = settle_inc;
                n_phase  = phase_inc;
                if (r_seq == tdss_pkg::SEQ_OPENING || r_seq == tdss_pkg::SEQ_CLOSING) begin
                    case (r_act)
                        tdss_pkg::DM_SINGLE: begin
                            chk_en    = 1'b1;
                            chk_ready = r_s1.door0_ready;
                        end
                        tdss_pkg::DM_SYNC: begin
                            chk_en    = 1'b1;
                            chk_ready = r_s1.door0_ready && r_s1.door1_ready;
                        end
                        tdss_pkg::DM_DELAY: begin
                            launch = !r_second
                                  && (tdss_pkg::t_cmp'(phase_inc)
                                      >= tdss_pkg::t_cmp'(cfg.lag_ticks));
                            chk_en    = 1'b1;
                            chk_ready = rf && (!(r_second || launch) || rs);
                        end
                        tdss_pkg::DM_SEQ: begin
                            if (!r_second) begin
                                launch = rf;
                            end else begin
                                chk_en    = 1'b1;
                                chk_ready = rs;
                            end
                        end
                        default: begin
                            n_seq   = tdss_pkg::SEQ_COMPLETE;
                            n_doors = r_dir ? tdss_pkg::DS_CLOSED : tdss_pkg::DS_OPEN;
                        end
                    endcase

                    // Start the second door: door 1 when opening, door 0 when closing.
                    if (launch) begin
                        n_second = 1'b1;
                        n_settle = '0;
                        if (r_dir) begin
                            cmd0_v  = 1'b1;
                            cmd0_us = cfg.door0_shut_pw;
                        end else begin
                            cmd1_v  = 1'b1;
                            cmd1_us = cfg.door1_open_pw;
                        end
                    end

                    // Settle timing: complete once ready long enough.
                    if (chk_en) begin
                        if (!chk_ready) begin
                            n_settle = '0;
                        end else if (tdss_pkg::t_cmp'(n_settle)
                                     >= tdss_pkg::t_cmp'(cfg.settle_ms)) begin
                            n_seq   = tdss_pkg::SEQ_COMPLETE;
                            n_doors = r_dir ? tdss_pkg::DS_CLOSED : tdss_pkg::DS_OPEN;
                        end
                    end
                end
            end
            tdss_pkg::KIND_START_OPEN, tdss_pkg::KIND_START_CLOSE: begin
                n_act = start_mode;
                if (start_mode == tdss_pkg::DM_NONE) begin
                    n_seq = tdss_pkg::SEQ_COMPLETE;
                end else begin
                    n_dir    = closing;
                    n_seq    = closing ? tdss_pkg::SEQ_CLOSING : tdss_pkg::SEQ_OPENING;
                    n_doors  = closing ? tdss_pkg::DS_CLOSING : tdss_pkg::DS_OPENING;
                    n_settle = '0;
                    n_phase  = '0;
                    n_second = 1'b0;
                    case (start_mode)
                        tdss_pkg::DM_SINGLE: begin
                            cmd0_v  = 1'b1;
                            cmd0_us = closing ? cfg.door0_shut_pw : cfg.door0_open_pw;
                        end
                        tdss_pkg::DM_SYNC: begin
                            cmd0_v  = 1'b1;
                            cmd0_us = closing ? cfg.door0_shut_pw : cfg.door0_open_pw;
                            cmd1_v  = 1'b1;
                            cmd1_us = closing ? cfg.door1_shut_pw : cfg.door1_open_pw;
                        end
                        tdss_pkg::DM_DELAY, tdss_pkg::DM_SEQ: begin
                            if (closing) begin
                                cmd1_v  = 1'b1;
                                cmd1_us = cfg.door1_shut_pw;
                            end else begin
                                cmd0_v  = 1'b1;
                                cmd0_us = cfg.door0_open_pw;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tdss_pkg::KIND_OPEN_NOW, tdss_pkg::KIND_CLOSE_NOW: begin
                if (cfg.pre_mode != tdss_pkg::DM_NONE) begin
                    cmd0_v  = 1'b1;
                    cmd0_us = closing ? cfg.door0_shut_pw : cfg.door0_open_pw;
                    if (cfg.pre_mode >= tdss_pkg::DM_SYNC) begin
                        cmd1_v  = 1'b1;
                        cmd1_us = closing ? cfg.door1_shut_pw : cfg.door1_open_pw;
                    end
                    n_doors = closing ? tdss_pkg::DS_CLOSED : tdss_pkg::DS_OPEN;
                end
            end
            tdss_pkg::KIND_SET_POS: begin
                if (r_s1.door_index) begin
                    cmd1_v  = 1'b1;
                    cmd1_us = r_s1.target_pw;
                end else begin
                    cmd0_v  = 1'b1;
                    cmd0_us = r_s1.target_pw;
                end
            end
            default: begin
            end
        endcase

        n_out.door0_cmd_valid     = cmd0_v;
        n_out.door0_cmd_us        = cmd0_us;
        n_out.door1_cmd_valid     = cmd1_v;
        n_out.door1_cmd_us        = cmd1_us;
        n_out.sequence_state      = n_seq;
        n_out.door_position_state = n_doors;
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_seq       <= tdss_pkg::SEQ_IDLE;
            r_doors     <= tdss_pkg::DS_CLOSED;
            r_act       <= tdss_pkg::DM_NONE;
            r_dir       <= 1'b0;
            r_second    <= 1'b0;
            r_settle    <= '0;
            r_phase     <= '0;
        end else begin
            if (i_item.ready) begin
                r_s1_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_seq       <= n_seq;
                r_doors     <= n_doors;
                r_act       <= n_act;
                r_dir       <= n_dir;
                r_second    <= n_second;
                r_settle    <= n_settle;
                r_phase     <= n_phase;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_s1.mode        <= i_item.mode;
            r_s1.deploying   <= i_item.deploying;
            r_s1.door_index  <= i_item.door_index;
            r_s1.target_pw   <= i_item.target_pw;
            r_s1.door0_ready <= i_item.door0_ready;
            r_s1.door1_ready <= i_item.door1_ready;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.door0_cmd_valid     = r_out.door0_cmd_valid;
    assign o_result.door0_cmd_us        = r_out.door0_cmd_us;
    assign o_result.door1_cmd_valid     = r_out.door1_cmd_valid;
    assign o_result.door1_cmd_us        = r_out.door1_cmd_us;
    assign o_result.sequence_state      = r_out.sequence_state;
    assign o_result.door_position_state = r_out.door_position_state;

    // A running sequence always has a door mode other than none behind it.
    `ASSERT_TOP(a_run_has_mode, (r_seq == tdss_pkg::SEQ_OPENING || r_seq == tdss_pkg::SEQ_CLOSING) |-> (r_act != tdss_pkg::DM_NONE), "sequence running with door mode none")

    // A stalled result freezes the sequencer state.
    `ASSERT_TOP(a_stall_holds_state, (r_out_valid && !o_result.ready) |=> $stable(r_seq) && $stable(r_settle) && $stable(r_phase), "sequencer state moved during a stall")

    // An idle command slot carries a zero pulse width.
    `ASSERT_TOP(a_idle_slot_zero, r_out_valid |-> (r_out.door0_cmd_valid || r_out.door0_cmd_us == 16'd0) && (r_out.door1_cmd_valid || r_out.door1_cmd_us == 16'd0), "idle command slot with nonzero width")

endmodule

// ===== src/tdss_regs.sv =====
// ----------------------------------------------------------------------------
// tdss_regs
// APB register file holding door pulse widths, door modes and timing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdss_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tdss_pkg::ADDR_W-1:0]   paddr,
    input  logic [tdss_pkg::DATA_W-1:0]   pwdata,
    output logic [tdss_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tdss_pkg::t_cfg                o_cfg
);

    tdss_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Register writes in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.door0_open_pw <= 16'd2000;
            r_cfg.door1_open_pw <= 16'd2000;
            r_cfg.door0_shut_pw <= 16'd1000;
            r_cfg.door1_shut_pw <= 16'd1000;
            r_cfg.pre_mode      <= tdss_pkg::DM_NONE;
            r_cfg.post_mode     <= tdss_pkg::DM_NONE;
            r_cfg.lag_ticks     <= 16'd500;
            r_cfg.settle_ms     <= 16'd200;
        end else if (wr_en) begin
            case (reg_idx)
                tdss_pkg::REG_OPEN0:     r_cfg.door0_open_pw <= pwdata[15:0];
                tdss_pkg::REG_OPEN1:     r_cfg.door1_open_pw <= pwdata[15:0];
                tdss_pkg::REG_CLOSE0:    r_cfg.door0_shut_pw <= pwdata[15:0];
                tdss_pkg::REG_CLOSE1:    r_cfg.door1_shut_pw <= pwdata[15:0];
                tdss_pkg::REG_PRE_MODE:  r_cfg.pre_mode      <= pwdata[2:0];
                tdss_pkg::REG_POST_MODE: r_cfg.post_mode     <= pwdata[2:0];
                tdss_pkg::REG_DELAY:     r_cfg.lag_ticks     <= pwdata[15:0];
                tdss_pkg::REG_SETTLE:    r_cfg.settle_ms     <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (reg_idx)
            tdss_pkg::REG_OPEN0:     prdata = {16'd0, r_cfg.door0_open_pw};
            tdss_pkg::REG_OPEN1:     prdata = {16'd0, r_cfg.door1_open_pw};
            tdss_pkg::REG_CLOSE0:    prdata = {16'd0, r_cfg.door0_shut_pw};
            tdss_pkg::REG_CLOSE1:    prdata = {16'd0, r_cfg.door1_shut_pw};
            tdss_pkg::REG_PRE_MODE:  prdata = {29'd0, r_cfg.pre_mode};
            tdss_pkg::REG_POST_MODE: prdata = {29'd0, r_cfg.post_mode};
            tdss_pkg::REG_DELAY:     prdata = {16'd0, r_cfg.lag_ticks};
            tdss_pkg::REG_SETTLE:    prdata = {16'd0, r_cfg.settle_ms};
            default:                 prdata = '0;
        endcase
    end

endmodule
